[sv/mst_pkg.sv]
`timescale 1ns / 1ps
// mst_pkg: shared types and constants of the spanning tree engine
// no dependencies

package mst_pkg;

    localparam int EP_W    = 6;   // endpoint index width
    localparam int WT_W    = 32;  // weight width
    localparam int EDGE_W  = 2 * EP_W + WT_W;
    localparam int QDEPTH  = 4;   // front to back queue depth
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;
    localparam int CFG_AW  = 3;   // apb address width
    localparam logic CFG_IDX_VCOUNT = 1'b0;

    // one edge transaction as it travels through the queue
    typedef struct packed {
        logic [EP_W-1:0]        from_v;
        logic [EP_W-1:0]        to_v;
        logic signed [WT_W-1:0] weight;
        logic                   last;
    } edge_item_t;

    // sequencer states of the back end
    typedef enum logic [7:0] {
        S_LOAD = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_RA   = 8'b0000_0100,
        S_RA_W = 8'b0000_1000,
        S_RB   = 8'b0001_0000,
        S_RB_W = 8'b0010_0000,
        S_LINK = 8'b0100_0000,
        S_MARK = 8'b1000_0000
    } back_state_t;

endpackage

[sv/mst_ram.sv]
`timescale 1ns / 1ps
// mst_ram: generic one write port, one read port ram with registered read
// no dependencies

module mst_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sv/mst_front.sv]
`timescale 1ns / 1ps
// mst_front: accepts edge transactions and queues them for the back end
// depends on mst_pkg

module mst_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [mst_pkg::EP_W-1:0] edge_from,
    input  logic [mst_pkg::EP_W-1:0] edge_to,
    input  logic signed [mst_pkg::WT_W-1:0] edge_weight,
    input  logic                     last_edge,
    output logic                     q_valid,
    output mst_pkg::edge_item_t      q_item,
    input  logic                     q_ready
);
    import mst_pkg::*;

    edge_item_t              q_mem [QDEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]       cnt_reg;
    logic                    push, pop;
    edge_item_t              item;

    // pack the incoming transaction
    always_comb
    begin
        item.from_v = edge_from;
        item.to_v   = edge_to;
        item.weight = edge_weight;
        item.last   = last_edge;
    end

    assign in_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= item;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[sv/mst_back.sv]
`timescale 1ns / 1ps
// mst_back: edge store, ordered selection passes and union-find sequencer
// depends on mst_pkg and mst_ram

module mst_back #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     q_valid,
    input  mst_pkg::edge_item_t      q_item,
    output logic                     q_ready,
    input  logic [6:0]               vertex_count,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     has_edge,
    output logic [mst_pkg::EP_W-1:0] tree_low_end,
    output logic [mst_pkg::EP_W-1:0] tree_high_end,
    output logic signed [mst_pkg::WT_W-1:0] tree_weight,
    output logic                     spanning,
    output logic                     last_result
);
    import mst_pkg::*;

    localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EW = $clog2(MAX_EDGES + 1);
    localparam int VI = $clog2(MAX_VERTICES);
    localparam int VW = $clog2(MAX_VERTICES + 1);
    localparam int CW = (VW > 7) ? VW : 7;

    back_state_t state_reg, state_next;

    logic [EW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  found_reg, found_next;
    logic [EW-1:0]  scan_reg, scan_next;
    logic           pend_reg, pend_next;
    logic [EW-1:0]  idx_reg, idx_next;

    logic                 lastv_reg, lastv_next;
    logic signed [WT_W-1:0] last_w_reg, last_w_next;
    logic [EW-1:0]        last_i_reg, last_i_next;

    logic                 bestv_reg, bestv_next;
    logic signed [WT_W-1:0] best_w_reg, best_w_next;
    logic [EW-1:0]        best_i_reg, best_i_next;
    logic [EP_W-1:0]      best_a_reg, best_a_next;
    logic [EP_W-1:0]      best_b_reg, best_b_next;

    logic [VI-1:0]  v_reg, v_next;
    logic [VI-1:0]  ra_reg, ra_next;
    logic [VI-1:0]  rb_reg, rb_next;
    logic [MAX_VERTICES-1:0] rvalid_reg, rvalid_next;

    // edge store ports
    logic            e_we;
    logic [AW-1:0]   e_waddr, e_raddr;
    logic [EDGE_W-1:0] e_wdata, e_rdata;

    // root table ports
    logic            r_we;
    logic [VI-1:0]   r_rdata;

    // output register
    logic                 ov_reg;
    logic                 o_has_reg, o_span_reg, o_last_reg;
    logic [EP_W-1:0]      o_lo_reg, o_hi_reg;
    logic signed [WT_W-1:0] o_w_reg;
    logic                 emit, emit_has, emit_done, slot_free;

    logic [CW-1:0]        vc, need, a_ext, b_ext;
    logic [EP_W-1:0]      rd_a, rd_b;
    logic signed [WT_W-1:0] rd_w;
    logic                 cand, better;
    logic [VI-1:0]        parent;

    mst_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES), .ADDR_W(AW)) u_edge_ram (
        .clk   (clk),
        .we    (e_we),
        .waddr (e_waddr),
        .wdata (e_wdata),
        .raddr (e_raddr),
        .rdata (e_rdata)
    );

    mst_ram #(.WIDTH(VI), .DEPTH(MAX_VERTICES), .ADDR_W(VI)) u_root_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (ra_reg),
        .wdata (rb_reg),
        .raddr (v_reg),
        .rdata (r_rdata)
    );

    // effective vertex count and tree size target
    always_comb
    begin
        if (vertex_count == '0)
        begin
            vc = CW'(1);
        end
        else if (CW'(vertex_count) > CW'(MAX_VERTICES))
        begin
            vc = CW'(MAX_VERTICES);
        end
        else
        begin
            vc = CW'(vertex_count);
        end
        need = vc - 1'b1;
    end

    // field split of the stored edge and pass compare
    assign rd_a   = e_rdata[EDGE_W-1 -: EP_W];
    assign rd_b   = e_rdata[EDGE_W-EP_W-1 -: EP_W];
    assign rd_w   = e_rdata[WT_W-1:0];
    assign cand   = !lastv_reg || (rd_w > last_w_reg) ||
                    ((rd_w == last_w_reg) && (idx_reg > last_i_reg));
    assign better = !bestv_reg || (rd_w < best_w_reg);
    assign a_ext  = CW'(best_a_reg);
    assign b_ext  = CW'(best_b_reg);
    assign parent = rvalid_reg[v_reg] ? r_rdata : v_reg;

    assign slot_free = !ov_reg || out_ready;
    assign q_ready   = (state_reg == S_LOAD);
    assign e_wdata   = {q_item.from_v, q_item.to_v, q_item.weight};
    assign e_waddr   = cnt_reg[AW-1:0];
    assign e_raddr   = scan_reg[AW-1:0];

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        found_next  = found_reg;
        scan_next   = scan_reg;
        pend_next   = 1'b0;
        idx_next    = idx_reg;
        lastv_next  = lastv_reg;
        last_w_next = last_w_reg;
        last_i_next = last_i_reg;
        bestv_next  = bestv_reg;
        best_w_next = best_w_reg;
        best_i_next = best_i_reg;
        best_a_next = best_a_reg;
        best_b_next = best_b_reg;
        v_next      = v_reg;
        ra_next     = ra_reg;
        rb_next     = rb_reg;
        rvalid_next = rvalid_reg;
        e_we        = 1'b0;
        r_we        = 1'b0;
        emit        = 1'b0;
        emit_has    = 1'b0;
        emit_done   = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                if (q_valid)
                begin
                    if (cnt_reg < EW'(MAX_EDGES))
                    begin
                        e_we     = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (q_item.last)
                    begin
                        lastv_next = 1'b0;
                        scan_next  = '0;
                        bestv_next = 1'b0;
                        state_next = (need == '0) ? S_MARK : S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // issue the next store read
                if (scan_reg < cnt_reg)
                begin
                    pend_next = 1'b1;
                    idx_next  = scan_reg;
                    scan_next = scan_reg + 1'b1;
                end
                // evaluate the returned edge
                if (pend_reg && cand && better)
                begin
                    bestv_next  = 1'b1;
                    best_w_next = rd_w;
                    best_i_next = idx_reg;
                    best_a_next = rd_a;
                    best_b_next = rd_b;
                end
                // end of pass
                if (!(scan_reg < cnt_reg) && !pend_reg)
                begin
                    scan_next = '0;
                    bestv_next = 1'b0;
                    if (!bestv_reg)
                    begin
                        state_next = S_MARK;
                    end
                    else
                    begin
                        lastv_next  = 1'b1;
                        last_w_next = best_w_reg;
                        last_i_next = best_i_reg;
                        if ((a_ext < vc) && (b_ext < vc))
                        begin
                            v_next     = a_ext[VI-1:0];
                            state_next = S_RA;
                        end
                    end
                end
            end
            S_RA:
            begin
                state_next = S_RA_W;
            end
            S_RA_W:
            begin
                if (parent == v_reg)
                begin
                    ra_next    = v_reg;
                    v_next     = b_ext[VI-1:0];
                    state_next = S_RB;
                end
                else
                begin
                    v_next     = parent;
                    state_next = S_RA;
                end
            end
            S_RB:
            begin
                state_next = S_RB_W;
            end
            S_RB_W:
            begin
                if (parent == v_reg)
                begin
                    rb_next    = v_reg;
                    state_next = (ra_reg == v_reg) ? S_SCAN : S_LINK;
                end
                else
                begin
                    v_next     = parent;
                    state_next = S_RB;
                end
            end
            S_LINK:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_has   = 1'b1;
                    emit_done  = ((found_reg + 1'b1) == need);
                    r_we       = 1'b1;
                    rvalid_next[ra_reg] = 1'b1;
                    found_next = found_reg + 1'b1;
                    state_next = S_SCAN;
                    if (emit_done)
                    begin
                        cnt_next    = '0;
                        found_next  = '0;
                        rvalid_next = '0;
                        state_next  = S_LOAD;
                    end
                end
            end
            S_MARK:
            begin
                if (slot_free)
                begin
                    emit        = 1'b1;
                    cnt_next    = '0;
                    found_next  = '0;
                    rvalid_next = '0;
                    state_next  = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            cnt_reg    <= '0;
            found_reg  <= '0;
            scan_reg   <= '0;
            pend_reg   <= 1'b0;
            lastv_reg  <= 1'b0;
            bestv_reg  <= 1'b0;
            rvalid_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            found_reg  <= found_next;
            scan_reg   <= scan_next;
            pend_reg   <= pend_next;
            lastv_reg  <= lastv_next;
            bestv_reg  <= bestv_next;
            rvalid_reg <= rvalid_next;
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        last_w_reg <= last_w_next;
        last_i_reg <= last_i_next;
        best_w_reg <= best_w_next;
        best_i_reg <= best_i_next;
        best_a_reg <= best_a_next;
        best_b_reg <= best_b_next;
        v_reg      <= v_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        if (emit)
        begin
            o_has_reg  <= emit_has;
            o_lo_reg   <= !emit_has ? '0 :
                          (best_a_reg < best_b_reg) ? best_a_reg : best_b_reg;
            o_hi_reg   <= !emit_has ? '0 :
                          (best_a_reg < best_b_reg) ? best_b_reg : best_a_reg;
            o_w_reg    <= emit_has ? best_w_reg : '0;
            o_span_reg <= emit_done;
            o_last_reg <= emit_done || !emit_has;
        end
    end

    assign out_valid     = ov_reg;
    assign has_edge      = o_has_reg;
    assign tree_low_end  = o_lo_reg;
    assign tree_high_end = o_hi_reg;
    assign tree_weight   = o_w_reg;
    assign spanning      = o_span_reg;
    assign last_result   = o_last_reg;

endmodule

[sv/minimum_spanning_tree_engine.sv]
`timescale 1ns / 1ps
// minimum_spanning_tree_engine: top level with apb register and front/back split
// depends on mst_pkg, mst_front, mst_back

// Edges load at one transaction per cycle while the back end is loading,
// through a four-entry queue into the edge store. After the edge flagged
// last, the engine runs selection passes over the n stored edges: each pass
// streams the whole store through its single read port and picks the next
// edge in ascending weight order, ties in arrival order; a candidate then
// walks the root table for each endpoint, each parent step a read, then a
// compare. Worst case is about n passes, plus the root walks; input
// transactions queue meanwhile and stall once the queue fills.
// No clearing pass is needed after reset.
module minimum_spanning_tree_engine #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 1024
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [mst_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [mst_pkg::EP_W-1:0] edge_from,
    input  logic [mst_pkg::EP_W-1:0] edge_to,
    input  logic signed [mst_pkg::WT_W-1:0] edge_weight,
    input  logic                     last_edge,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     has_edge,
    output logic [mst_pkg::EP_W-1:0] tree_low_end,
    output logic [mst_pkg::EP_W-1:0] tree_high_end,
    output logic signed [mst_pkg::WT_W-1:0] tree_weight,
    output logic                     spanning,
    output logic                     last_result
);
    import mst_pkg::*;

    logic [6:0]  vcount_reg;
    logic        q_valid, q_ready;
    edge_item_t  q_item;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= 7'd64;
        end
        else if (psel && penable && pwrite && (paddr[2] == CFG_IDX_VCOUNT))
        begin
            vcount_reg <= pwdata[6:0];
        end
    end
    assign prdata = (paddr[2] == CFG_IDX_VCOUNT) ? {25'd0, vcount_reg} : 32'd0;

    mst_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .edge_from   (edge_from),
        .edge_to     (edge_to),
        .edge_weight (edge_weight),
        .last_edge   (last_edge),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_ready     (q_ready)
    );

    mst_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_ready       (q_ready),
        .vertex_count  (vcount_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .has_edge      (has_edge),
        .tree_low_end  (tree_low_end),
        .tree_high_end (tree_high_end),
        .tree_weight   (tree_weight),
        .spanning      (spanning),
        .last_result   (last_result)
    );

endmodule

[sv/mst_checker.sv]
`timescale 1ns / 1ps
// mst_checker: port level assertions for the spanning tree engine
// depends on mst_pkg; bound to minimum_spanning_tree_engine

module mst_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     pready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic                     has_edge,
    input logic [mst_pkg::EP_W-1:0] tree_low_end,
    input logic [mst_pkg::EP_W-1:0] tree_high_end,
    input logic [mst_pkg::WT_W-1:0] tree_weight,
    input logic                     spanning,
    input logic                     last_result
);

    // stalled result stays valid with weight, low end and edge flag held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tree_weight)
            && $stable(tree_low_end) && $stable(has_edge))
        else $error("result changed while stalled");

    // register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    // end marker is a closing, non spanning result
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_edge |-> last_result && !spanning)
        else $error("bad end marker");

    // spanning flag only on the final tree edge
    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && spanning |-> last_result && has_edge)
        else $error("spanning on wrong result");

    // endpoints come ordered
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && has_edge |-> tree_low_end < tree_high_end)
        else $error("endpoints out of order");

endmodule

bind minimum_spanning_tree_engine mst_checker u_mst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pready        (pready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .has_edge      (has_edge),
    .tree_low_end  (tree_low_end),
    .tree_high_end (tree_high_end),
    .tree_weight   (tree_weight),
    .spanning      (spanning),
    .last_result   (last_result)
);
